// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the spring force accumulator RTL.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked even while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/sfa_pkg.sv
// Package for the spring force accumulator: payload structs, register
// indexes, sequencer states and the shared unit's operation codes. No dependencies.
`default_nettype none
package sfa_pkg;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               in_volume;
        logic signed [31:0] diff_x;
        logic signed [31:0] diff_y;
        logic signed [31:0] diff_z;
        logic               neighbour_active;
        logic               diagonal;
        logic               pass_start;
        logic               last_term;
    } sfa_in_t;

    typedef struct packed {
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic [30:0]        force_mag;
        logic [30:0]        largest_mag;
    } sfa_out_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_EDGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST_DIAG   = 2'd2;

    localparam logic [15:0] GAIN_RESET      = 16'd1638;
    localparam logic [23:0] REST_EDGE_RESET = 24'd196608;
    localparam logic [23:0] REST_DIAG_RESET = 24'd278046;
    localparam int GAIN_BITS = 16;

    // Shared iterative unit: square root or unsigned divide.
    typedef enum logic [0:0] {
        OP_SQRT,
        OP_DIV
    } sfa_op_t;

    typedef struct packed {
        logic    start;
        sfa_op_t op;
    } sfa_unit_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_DIST,
        ST_FORCE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_Z,
        ST_TERM,
        ST_MAG_SQ,
        ST_MAG,
        ST_OUT
    } sfa_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/sfa_iter_unit.sv
// Shared iterative unit: 64-bit floor square root (two bits a step) and
// 64/34-bit unsigned restoring divide (one bit a step). Uses sfa_pkg.
`default_nettype none
`include "assert_macros.svh"
module sfa_iter_unit
    import sfa_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sfa_unit_ctl_t ctl,
    input  wire logic [63:0]   opa,
    input  wire logic [33:0]   opb,
    output logic               done,
    output logic [63:0]        result
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    sfa_op_t     op_reg, op_next;
    logic [63:0] a_reg, a_next;
    logic [65:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [33:0] b_reg, b_next;
    logic        done_reg, done_next;

    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        trial     = '0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            a_next    = opa;
            b_next    = opb;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = (ctl.op == OP_SQRT) ? 7'd32 : 7'd64;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_SQRT:
                begin
                    // Digit-by-digit root: bring down two bits, try 4q+1.
                    rem_sh = {rem_reg[63:0], a_reg[63:62]};
                    trial  = {q_reg[63:0], 2'b01};
                    a_next = {a_reg[61:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                end
                OP_DIV:
                begin
                    rem_sh = {rem_reg[64:0], a_reg[63]};
                    trial  = {32'd0, b_reg};
                    a_next = {a_reg[62:0], 1'b0};
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            op_reg   <= OP_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = q_reg;

    `ASSERT_CLK(a_no_start_busy, busy_reg |-> !ctl.start, "unit restarted while busy")
    `ASSERT_CLK(a_done_after_busy, done_reg |-> $past(busy_reg), "done without work")
    `ASSERT_ALWAYS(a_cnt_idle, (!rst_n || busy_reg || ctl.start) || cnt_reg == 7'd0,
        "count left over when idle")

endmodule
`default_nettype wire

// File: hw/rtl/sfa_ctrl.sv
// Sequencer states for the accumulator: next-state logic and unit control.
// Uses sfa_pkg.
`default_nettype none
module sfa_ctrl
    import sfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic       do_term,
    input  wire logic       is_last,
    input  wire logic       dist_zero,
    input  wire logic       unit_done,
    input  wire logic       out_fire,
    output sfa_state_t      state,
    output sfa_unit_ctl_t   unit_ctl
);

    sfa_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = do_term ? ST_SQ : (is_last ? ST_MAG_SQ : ST_IDLE);
            ST_SQ:    state_next = ST_DIST;
            ST_DIST:
                if (unit_done)
                    state_next = ST_FORCE;
            ST_FORCE:
                if (dist_zero)
                    state_next = is_last ? ST_MAG_SQ : ST_IDLE;
                else
                    state_next = ST_DIV_X;
            ST_DIV_X: if (unit_done) state_next = ST_DIV_Y;
            ST_DIV_Y: if (unit_done) state_next = ST_DIV_Z;
            ST_DIV_Z: if (unit_done) state_next = ST_TERM;
            ST_TERM:  state_next = is_last ? ST_MAG_SQ : ST_IDLE;
            ST_MAG_SQ: state_next = ST_MAG;
            ST_MAG:   if (unit_done) state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        unit_ctl.start = 1'b0;
        unit_ctl.op    = OP_SQRT;
        case (state_reg)
            ST_SQ:
            begin
                unit_ctl.start = 1'b1;
            end
            ST_FORCE:
            begin
                unit_ctl.start = !dist_zero;
                unit_ctl.op    = OP_DIV;
            end
            ST_DIV_X, ST_DIV_Y:
            begin
                unit_ctl.start = unit_done;
                unit_ctl.op    = OP_DIV;
            end
            ST_MAG_SQ:
            begin
                unit_ctl.start = 1'b1;
            end
            default:
            begin
                unit_ctl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule
`default_nettype wire

// File: hw/rtl/spring_force_accumulator.sv
// Top level of the spring force accumulator: registers, datapath and output word.
// Depends on sfa_pkg, sfa_ctrl, sfa_iter_unit and assert_macros.svh.
//
//  channel | signals                  | direction | word
//  in      | in_valid, in_ready, in   | input     | sfa_in_t
//  out     | out_valid, out_ready, out| output    | sfa_out_t
//  cfg     | cfg_we, cfg_idx, cfg_data| input     | 24-bit register data
//
// A term with an active neighbour runs, from its acceptance to the next, through
// a square root, three divides on the shared unit and four single steps.
// A zero distance skips the divides; an inactive non-last term leaves the block idle.
// A last term adds the magnitude root and the output, plus any out_ready stall.
// The block takes no new word until the result word has been taken.
// Reset clears the sums, the largest magnitude and the run flag.
`default_nettype none
`include "assert_macros.svh"
module spring_force_accumulator
    import sfa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sfa_in_t               in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output sfa_out_t                   out,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic [15:0] gain_reg;
    logic [23:0] rest_edge_reg, rest_diag_reg;
    logic signed [31:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [30:0] largest_reg;
    logic        in_run_reg;
    sfa_in_t     item_reg;
    logic [33:0] dist_reg;
    logic signed [47:0] f_reg;
    logic signed [FRAC_BITS+1:0] ux_reg, uy_reg, uz_reg;
    logic [30:0] mag_reg;

    sfa_state_t    state;
    sfa_unit_ctl_t unit_ctl;
    logic          unit_done;
    logic [63:0]   unit_res;
    logic [63:0]   unit_a;
    logic          in_fire, out_fire;

    assign in_ready  = (state == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state == ST_OUT);
    assign out_fire  = out_valid && out_ready;

    function automatic logic [63:0] abs64(input logic signed [31:0] v);
        logic [32:0] m;
        begin
            m = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
            abs64 = {31'd0, m};
        end
    endfunction

    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                    input int k);
        logic [63:0] m;
        begin
            m = v[63] ? (64'd0 - v) : v;
            m = (m + (64'd1 << (k - 1))) >> k;
            rnd_shr = v[63] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[31], {32{a[31]}}, a} + {b[63], b};
            if (s > 65'sd2147483647)
                sat_add = S32_MAX;
            else if (s < -65'sd2147483648)
                sat_add = S32_MIN;
            else
                sat_add = s[31:0];
        end
    endfunction

    // Square sum of the magnitudes; reused for the term and for the output.
    logic [31:0] ax, ay, az;
    logic [63:0] px, py, pz;
    logic [65:0] sqsum;
    logic signed [31:0] sx_sel, sy_sel, sz_sel;
    always_comb
    begin
        if (state == ST_SQ)
        begin
            sx_sel = item_reg.diff_x;
            sy_sel = item_reg.diff_y;
            sz_sel = item_reg.diff_z;
        end
        else
        begin
            sx_sel = sum_x_reg;
            sy_sel = sum_y_reg;
            sz_sel = sum_z_reg;
        end
        ax = sx_sel[31] ? (32'd0 - $unsigned(sx_sel)) : $unsigned(sx_sel);
        ay = sy_sel[31] ? (32'd0 - $unsigned(sy_sel)) : $unsigned(sy_sel);
        az = sz_sel[31] ? (32'd0 - $unsigned(sz_sel)) : $unsigned(sz_sel);
        px = ax * ax;
        py = ay * ay;
        pz = az * az;
        sqsum = {2'b0, px} + {2'b0, py} + {2'b0, pz};
    end

    // Divide operand: |d| shifted by FRAC_BITS.
    logic signed [31:0] div_d;
    always_comb
    begin
        case (state)
            ST_FORCE: div_d = item_reg.diff_x;
            ST_DIV_X: div_d = item_reg.diff_y;
            default:  div_d = item_reg.diff_z;
        endcase
    end
    assign unit_a = (unit_ctl.op == OP_DIV) ? (abs64(div_d) << FRAC_BITS) : sqsum[63:0];

    sfa_iter_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (unit_ctl),
        .opa    (unit_a),
        .opb    (dist_reg),
        .done   (unit_done),
        .result (unit_res)
    );

    sfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .do_term   (in.neighbour_active),
        .is_last   (in_ready ? in.last_term : item_reg.last_term),
        .dist_zero (dist_reg == 34'd0),
        .unit_done (unit_done),
        .out_fire  (out_fire),
        .state     (state),
        .unit_ctl  (unit_ctl)
    );

    logic                        q_neg;
    logic signed [FRAC_BITS+1:0] q_signed;
    logic signed [31:0] seed_x, seed_y, seed_z;
    logic [23:0] rest_sel;
    logic signed [63:0] fprod;
    logic signed [63:0] f_full;
    always_comb
    begin
        // The quotient that just finished belongs to the axis of the current state.
        case (state)
            ST_DIV_X: q_neg = item_reg.diff_x[31];
            ST_DIV_Y: q_neg = item_reg.diff_y[31];
            default:  q_neg = item_reg.diff_z[31];
        endcase
        q_signed = q_neg ? -$signed(unit_res[FRAC_BITS+1:0])
                         : $signed(unit_res[FRAC_BITS+1:0]);
        seed_x = in.in_volume ? in.field_x : 32'sd0;
        seed_y = in.in_volume ? in.field_y : 32'sd0;
        seed_z = in.in_volume ? in.field_z : 32'sd0;
        rest_sel = item_reg.diagonal ? rest_diag_reg : rest_edge_reg;
        fprod = $signed({1'b0, gain_reg}) *
                ($signed({10'd0, rest_sel}) - $signed({1'b0, dist_reg}));
        f_full = rnd_shr(fprod, GAIN_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            rest_edge_reg <= REST_EDGE_RESET;
            rest_diag_reg <= REST_DIAG_RESET;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            largest_reg   <= '0;
            in_run_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_SPRING_GAIN: gain_reg      <= cfg_data[15:0];
                    REG_REST_EDGE:   rest_edge_reg <= cfg_data;
                    REG_REST_DIAG:   rest_diag_reg <= cfg_data;
                    default:         gain_reg      <= gain_reg;
                endcase
            end
            if (in_fire)
            begin
                if (in.pass_start)
                    largest_reg <= '0;
                if (!in_run_reg)
                begin
                    sum_x_reg <= seed_x;
                    sum_y_reg <= seed_y;
                    sum_z_reg <= seed_z;
                end
                in_run_reg <= 1'b1;
            end
            if (state == ST_TERM)
            begin
                sum_x_reg <= sat_add(sum_x_reg, rnd_shr(f_reg * ux_reg, FRAC_BITS));
                sum_y_reg <= sat_add(sum_y_reg, rnd_shr(f_reg * uy_reg, FRAC_BITS));
                sum_z_reg <= sat_add(sum_z_reg, rnd_shr(f_reg * uz_reg, FRAC_BITS));
            end
            if (state == ST_MAG && unit_done)
            begin
                if (unit_res[30:0] > largest_reg || unit_res[63:31] != '0)
                    largest_reg <= (unit_res[63:31] != '0) ? 31'h7FFF_FFFF : unit_res[30:0];
            end
            if (out_fire)
                in_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in;
        if (state == ST_DIST && unit_done)
            dist_reg <= unit_res[33:0];
        if (state == ST_FORCE)
            f_reg <= f_full[47:0];
        if (unit_done && state == ST_DIV_X)
            ux_reg <= q_signed;
        if (unit_done && state == ST_DIV_Y)
            uy_reg <= q_signed;
        if (unit_done && state == ST_DIV_Z)
            uz_reg <= q_signed;
        if (state == ST_MAG && unit_done)
            mag_reg <= (unit_res[63:31] != '0) ? 31'h7FFF_FFFF : unit_res[30:0];
    end

    assign out.acc_x       = sum_x_reg;
    assign out.acc_y       = sum_y_reg;
    assign out.acc_z       = sum_z_reg;
    assign out.force_mag   = mag_reg;
    assign out.largest_mag = largest_reg;

    `ASSERT_CLK(a_out_largest, out_valid |-> out.largest_mag >= out.force_mag,
        "largest below current magnitude")
    `ASSERT_CLK(a_no_in_while_out, out_valid |-> !in_ready, "input open while result waits")
    `ASSERT_CLK(a_run_after_out, out_fire |=> !in_run_reg, "run flag kept after result")

endmodule
`default_nettype wire
